FILE: src/linear_interp_audio_resampler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the resampler
// Shared property wrappers; each use stands on a line of its own.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_AUDIO_RESAMPLER_MACROS_SVH
`define LINEAR_INTERP_AUDIO_RESAMPLER_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define LIRS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define LIRS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

FILE: src/lirs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lirs_pkg
// Widths, constants and shared types of the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lirs_pkg;

  localparam int unsigned MaxChannels = 8;
  localparam int unsigned ChW         = $clog2(MaxChannels);
  localparam int unsigned AddrW       = ChW + 1;
  localparam int unsigned NchW        = 4;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned PhaseW      = FracBits + 5;
  localparam int unsigned MaxResults  = 32;
  localparam int unsigned CntW        = $clog2(MaxResults) + 2;
  localparam int unsigned StepW       = 21;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 21;

  localparam logic [PhaseW-1:0] PhaseOne = PhaseW'(1) << FracBits;
  localparam logic [PhaseW-1:0] PhaseMax = {PhaseW{1'b1}};

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgNumChannels = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRateStep    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgStartPhase  = 2'd2;

  // Frame store write request
  typedef struct packed {
    logic               en;
    logic [AddrW-1:0]   addr;
    logic [SampleW-1:0] data;
  } lirs_wr_t;

endpackage
`default_nettype wire

FILE: src/lirs_frame_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lirs_frame_mem
// Two-bank frame store: one write port, two registered read ports. Entries
// never written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module lirs_frame_mem (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire lirs_pkg::lirs_wr_t             wr_i,
  input  wire logic [lirs_pkg::AddrW-1:0]     rd_addr_a_i,
  input  wire logic [lirs_pkg::AddrW-1:0]     rd_addr_b_i,
  output logic signed [lirs_pkg::SampleW-1:0] rd_data_a_o,
  output logic signed [lirs_pkg::SampleW-1:0] rd_data_b_o
);
  import lirs_pkg::*;

  localparam int unsigned Depth = 2 ** AddrW;

  logic [SampleW-1:0] mem [Depth];
  logic [Depth-1:0]   valid_q;
  logic [SampleW-1:0] raw_a_q, raw_b_q;
  logic               va_q, vb_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    raw_a_q <= mem[rd_addr_a_i];
    raw_b_q <= mem[rd_addr_b_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      va_q <= valid_q[rd_addr_a_i];
      vb_q <= valid_q[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = va_q ? raw_a_q : '0;
  assign rd_data_b_o = vb_q ? raw_b_q : '0;

endmodule
`default_nettype wire

FILE: src/linear_interp_audio_resampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// linear_interp_audio_resampler
// Linear interpolation sample-rate converter for interleaved 16-bit audio.
//
// Samples enter one item at a time, channel by channel. When the last
// sample of a frame arrives, the block stops taking items, passes through a
// set-up state (S_PREP) that starts the first read of the frame store, then
// produces one interpolated result per cycle (while the output side takes
// them) for every position that falls between the previous and the new
// frame, channel by channel, up to 32 results. Input is taken again in the
// cycle after the last result is loaded into the output register. Results
// come from the single shared multiplier, which reads one entry pair of the
// frame store per cycle. The very first frame only primes the store. The
// output register lets the last result wait while the next input items are
// already taken.
// ----------------------------------------------------------------------------
`include "linear_interp_audio_resampler_macros.svh"

module linear_interp_audio_resampler (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [lirs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [lirs_pkg::CfgDataW-1:0]   cfg_data_i,
  // input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [15:0]                     s_axis_tdata,  // [15:0] in_sample
  // output stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [23:0]                          m_axis_tdata,  // [15:0] out_sample,
                                                              // [18:16] out_channel
  output logic                                 m_axis_tlast   // run_last
);
  import lirs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  // Configuration registers; a start phase write only loads the phase, and only before priming
  logic [NchW-1:0]     num_ch_q, num_ch_d;
  logic [StepW-1:0]    step_q, step_d;

  // Block state
  logic [1:0]          state_q, state_d;
  logic [ChW-1:0]      cin_q, cin_d;     // channel index of the next input item
  logic [PhaseW-1:0]   phase_q, phase_d;
  logic                primed_q, primed_d;
  logic                bank_q, bank_d;   // bank holding the newer frame
  logic [ChW-1:0]      ch_q, ch_d;       // channel being emitted
  logic [CntW-1:0]     cnt_q, cnt_d;     // results emitted this frame

  // Output register
  logic                  out_valid_q, out_valid_d;
  logic [SampleW-1:0]    out_sample_q;
  logic [ChW-1:0]        out_ch_q;
  logic                  out_last_q;

  // Frame store interface
  lirs_wr_t                   wr;
  logic [AddrW-1:0]           rd_addr_a, rd_addr_b;
  logic signed [SampleW-1:0]  smp_a, smp_b;

  // Datapath
  logic [NchW-1:0]            nch;
  logic                       in_acc;
  logic                       frame_done;
  logic                       load;
  logic                       last_ch;
  logic [PhaseW:0]            phase_sum;
  logic [PhaseW-1:0]          phase_sat;
  logic [CntW-1:0]            cnt_next;
  logic                       go_on;
  logic signed [SampleW:0]    diff;
  logic signed [2*SampleW+1:0] prod;
  logic signed [2*SampleW+1:0] acc;
  logic [SampleW-1:0]         lerp;

  // Clamp the channel count: zero counts as one, large values as the maximum
  always_comb begin
    nch = num_ch_q;
    if (num_ch_q == '0) begin
      nch = NchW'(1);
    end else if (num_ch_q > NchW'(MaxChannels)) begin
      nch = NchW'(MaxChannels);
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign frame_done    = ({1'b0, cin_q} + NchW'(1)) >= nch;

  assign load    = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready);
  assign last_ch = ({1'b0, ch_q} + NchW'(1)) == nch;

  // Phase advance after the last channel of a position, saturated
  assign phase_sum = {1'b0, phase_q} + (PhaseW + 1)'(step_q);
  assign phase_sat = (phase_sum > {1'b0, PhaseMax}) ? PhaseMax : phase_sum[PhaseW-1:0];
  assign cnt_next  = cnt_q + CntW'(nch);
  assign go_on     = (phase_sat < PhaseOne) &&
                     ((cnt_next + CntW'(nch)) <= CntW'(MaxResults));

  // Interpolate: a + (b - a) * f, then floor by the fraction width.
  // Widen both factors to the product width so the full 17 x 17 product holds.
  assign diff = {smp_b[SampleW-1], smp_b} - {smp_a[SampleW-1], smp_a};
  assign prod = $signed({{(SampleW+1){diff[SampleW]}}, diff}) *
                $signed({{(SampleW+1){1'b0}}, 1'b0, phase_q[FracBits-1:0]});
  assign acc  = $signed({{(SampleW+2){smp_a[SampleW-1]}}, smp_a} << FracBits) + prod;
  assign lerp = acc[FracBits +: SampleW];

  // Write the incoming sample into the older bank
  always_comb begin
    wr.en   = in_acc;
    wr.addr = {~bank_q, cin_q};
    wr.data = s_axis_tdata[SampleW-1:0];
  end

  // Read address follows the next channel so data lines up with ch_q
  assign rd_addr_a = {~bank_q, ch_d};
  assign rd_addr_b = {bank_q, ch_d};

  lirs_frame_mem u_frame_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (smp_a),
    .rd_data_b_o (smp_b)
  );

  always_comb begin
    num_ch_d    = num_ch_q;
    step_d      = step_q;
    state_d     = state_q;
    cin_d       = cin_q;
    phase_d     = phase_q;
    primed_d    = primed_q;
    bank_d      = bank_q;
    ch_d        = ch_q;
    cnt_d       = cnt_q;
    out_valid_d = m_axis_tready ? 1'b0 : out_valid_q;

    // Configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgNumChannels: num_ch_d = cfg_data_i[NchW-1:0];
        CfgRateStep:    step_d   = cfg_data_i[StepW-1:0];
        CfgStartPhase: begin
          if (!primed_q) begin
            phase_d = PhaseW'(cfg_data_i[FracBits-1:0]);
          end
        end
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!frame_done) begin
            cin_d = cin_q + ChW'(1);
          end else begin
            // Swap banks: the frame just completed becomes the newer one
            cin_d  = '0;
            bank_d = ~bank_q;
            if (!primed_q) begin
              primed_d = 1'b1;
            end else begin
              state_d = S_PREP;
              ch_d    = '0;
            end
          end
        end
      end
      S_PREP: begin
        ch_d  = '0;
        cnt_d = '0;
        if (phase_q >= PhaseOne) begin
          // No position in this frame: drop one frame of phase
          phase_d = phase_q - PhaseOne;
          state_d = S_IDLE;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load) begin
          out_valid_d = 1'b1;
          if (!last_ch) begin
            ch_d = ch_q + ChW'(1);
          end else begin
            ch_d  = '0;
            cnt_d = cnt_next;
            if (go_on) begin
              phase_d = phase_sat;
            end else begin
              phase_d = (phase_sat >= PhaseOne) ? phase_sat - PhaseOne : phase_sat;
              state_d = S_IDLE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ch_q    <= NchW'(2);
      step_q      <= StepW'(65536);
      state_q     <= S_IDLE;
      cin_q       <= '0;
      phase_q     <= '0;
      primed_q    <= 1'b0;
      bank_q      <= 1'b0;
      ch_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      num_ch_q    <= num_ch_d;
      step_q      <= step_d;
      state_q     <= state_d;
      cin_q       <= cin_d;
      phase_q     <= phase_d;
      primed_q    <= primed_d;
      bank_q      <= bank_d;
      ch_q        <= ch_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload, held while the item waits
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_sample_q <= lerp;
      out_ch_q     <= ch_q;
      out_last_q   <= last_ch && !go_on;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_ch_q, out_sample_q};
  assign m_axis_tlast  = out_last_q;

  `LIRS_ASSERT(a_emit_ch_range, clk_i, rst_ni, (state_q == S_EMIT) |-> ({1'b0, ch_q} < nch), "emit channel beyond channel count")
  `LIRS_ASSERT(a_emit_phase_frac, clk_i, rst_ni, (state_q == S_EMIT) |-> (phase_q < PhaseOne), "emitting with whole phase")
  `LIRS_ASSERT(a_cnt_cap, clk_i, rst_ni, (state_q == S_EMIT) |-> ((cnt_q + CntW'(nch)) <= CntW'(MaxResults)), "result cap overrun")
  `LIRS_ASSERT(a_last_ends, clk_i, rst_ni, (load && last_ch && !go_on) |=> (state_q == S_IDLE), "frame run did not end after last result")
  `LIRS_ASSERT_NEVER(a_no_write_busy, clk_i, rst_ni, wr.en && (state_q != S_IDLE), "frame store written while emitting")

endmodule
`default_nettype wire

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench of the linear interpolation audio resampler
// Streams interleaved 16-bit samples into the block under random idling on
// both sides, predicts every interpolated result from its own copy of the
// frame store and phase, and compares each result field by field.
// ----------------------------------------------------------------------------
module tb;

  import lirs_pkg::*;

  // Register index that selects no register; a write there must do nothing
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  // Idle wait after the last result
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned LongHold     = 300;

  // One interpolated result as it leaves the block
  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic [ChW-1:0]     channel;
    logic               last;
  } resamp_out_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata  = '0;  // [15:0] in_sample
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;        // [15:0] out_sample, [18:16] out_channel
  logic                m_axis_tlast;        // run_last

  linear_interp_audio_resampler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shadow of the block: registers, frame store, phase and the results owed
  // --------------------------------------------------------------------------
  logic [NchW-1:0]           sh_nch   = 4'd2;
  logic [StepW-1:0]          sh_step  = 21'd65536;
  logic signed [SampleW-1:0] frame_old [MaxChannels];
  logic signed [SampleW-1:0] frame_new [MaxChannels];
  logic [ChW-1:0]            fill_idx = '0;
  logic [PhaseW-1:0]         phase    = '0;
  bit                        primed_q = 1'b0;

  resamp_out_t owed_q [$];

  // Run statistics and idling controls
  int unsigned n_errors  = 0;
  int unsigned n_items   = 0;
  int unsigned n_results = 0;
  int unsigned n_writes  = 0;
  bit          idle_on   = 1'b1;
  int unsigned rx_hold   = 0;

  initial begin
    for (int k = 0; k < MaxChannels; k++) begin
      frame_old[k] = '0;
      frame_new[k] = '0;
    end
  end

  // Channel count as the block uses it: 0 counts as 1, above 8 as 8
  function automatic int unsigned live_channels();
    int unsigned n;
    n = sh_nch;
    if (n == 0) n = 1;
    if (n > MaxChannels) n = MaxChannels;
    return n;
  endfunction

  // Mirror a register write in the shadow
  task automatic shadow_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    case (idx)
      CfgNumChannels: sh_nch = val[NchW-1:0];
      CfgRateStep:    sh_step = val[StepW-1:0];
      CfgStartPhase: begin
        // Before the first frame the phase follows the register
        if (!primed_q) phase = PhaseW'(val[FracBits-1:0]);
      end
      default: ;
    endcase
  endtask

  // Take one sample into the shadow and queue every result it causes
  task automatic interpolate_sample(input logic [SampleW-1:0] raw);
    int unsigned           nch;
    int unsigned           idx;
    int unsigned           cnt;
    logic signed [SampleW-1:0] swap_v;
    longint                acc;
    logic [PhaseW:0]       ph_sum;
    resamp_out_t           r;
    nch = live_channels();
    idx = fill_idx;
    if (idx >= MaxChannels) idx = MaxChannels - 1;
    frame_old[idx] = raw;
    // Frame still open: hold and wait for the next channel
    if (idx + 1 < nch) begin
      fill_idx = ChW'(idx + 1);
      return;
    end
    fill_idx = '0;
    for (int k = 0; k < MaxChannels; k++) begin
      swap_v       = frame_old[k];
      frame_old[k] = frame_new[k];
      frame_new[k] = swap_v;
    end
    // The first whole frame only primes the store
    if (!primed_q) begin
      primed_q = 1'b1;
      return;
    end
    cnt = 0;
    // Emit positions while the phase lies inside this pair and they fit the cap
    while (phase < PhaseOne && cnt + nch <= MaxResults) begin
      for (int j = 0; j < nch; j++) begin
        acc = longint'(frame_old[j]) * longint'(PhaseOne - phase)
            + longint'(frame_new[j]) * longint'(phase);
        r.sample  = acc[FracBits +: SampleW];  // floor of acc / ONE
        r.channel = ChW'(j);
        r.last    = 1'b0;
        owed_q.push_back(r);
        cnt++;
      end
      ph_sum = {1'b0, phase} + {1'b0, sh_step};
      phase  = (ph_sum > {1'b0, PhaseMax}) ? PhaseMax : ph_sum[PhaseW-1:0];
    end
    // Drop one frame of phase, unless the cap left it behind
    if (phase >= PhaseOne) phase = phase - PhaseOne;
    if (cnt > 0) begin
      r      = owed_q.pop_back();
      r.last = 1'b1;
      owed_q.push_back(r);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one item, sometimes after a random gap, and predict once it is taken
  task automatic send_sample(input logic [SampleW-1:0] smp);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
    interpolate_sample(smp);
    n_items++;
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_sample(SampleW'($urandom));
  endtask

  // Stop offering and hold until every owed result has come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (owed_q.size() != 0) @(posedge clk_i);
  endtask

  // Drain, then let a frame with no output finish its work
  task automatic settle();
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write one register; call only once the block is idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    shadow_write(idx, val);
    n_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random stalls, and a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : rx_side
    int unsigned n;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_hold != 0) begin
        n       = rx_hold;
        rx_hold = 0;
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Compare each accepted result with the oldest one owed
  always @(posedge clk_i) begin : check_results
    resamp_out_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (owed_q.size() == 0) begin
        $error("unexpected result: out_sample %0h out_channel %0d run_last %0b",
               m_axis_tdata[15:0], m_axis_tdata[18:16], m_axis_tlast);
        n_errors++;
      end else begin
        w = owed_q.pop_front();
        if (m_axis_tdata[15:0] !== w.sample) begin
          $error("out_sample: expected %0h, actual %0h", w.sample, m_axis_tdata[15:0]);
          n_errors++;
        end
        if (m_axis_tdata[18:16] !== w.channel) begin
          $error("out_channel: expected %0d, actual %0d", w.channel, m_axis_tdata[18:16]);
          n_errors++;
        end
        if (m_axis_tlast !== w.last) begin
          $error("run_last: expected %0b, actual %0b", w.last, m_axis_tlast);
          n_errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Load the start phase before priming, then push full-scale and near-zero frames
  task automatic test_priming_and_extremes();
    write_reg(CfgStartPhase, 21'h01234);
    write_reg(CfgStartPhase, 21'h0FFFF);   // last write before priming wins
    write_reg(CfgNumChannels, 21'd2);
    write_reg(CfgRateStep, 21'd65536);
    write_reg(CfgUnused, 21'h1FFFFF);      // selects nothing
    send_sample(16'h8000);                 // priming frame
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    settle();
  endtask

  // Channel counts of 0 and 15 fold back to 1 and 8
  task automatic test_channel_limits();
    write_reg(CfgRateStep, 21'd32768);
    write_reg(CfgNumChannels, 21'd0);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    settle();
    write_reg(CfgNumChannels, 21'd15);
    for (int k = 0; k < MaxChannels; k++)
      send_sample((k % 2 == 0) ? 16'h8000 : 16'h7FFF);
    settle();
  endtask

  // Shrink the channel count while a frame is half filled
  task automatic test_midframe_change();
    write_reg(CfgNumChannels, 21'd4);
    send_sample(16'h1234);
    send_sample(16'hEDCB);
    settle();
    write_reg(CfgNumChannels, 21'd2);
    send_sample(16'h4000);                 // index 2 closes the frame at once
    settle();
  endtask

  // A zero step never leaves the pair: every frame hits the result cap
  task automatic test_result_cap();
    write_reg(CfgNumChannels, 21'd3);
    write_reg(CfgRateStep, 21'd0);
    send_random(6);
    settle();
  endtask

  // Saturate the phase, then pass over frames until it falls back
  task automatic test_phase_overflow();
    write_reg(CfgNumChannels, 21'd1);
    write_reg(CfgRateStep, 21'h1FFFFF);
    send_random(4);
    settle();
    write_reg(CfgRateStep, 21'd40000);
    send_random(34);
    settle();
  endtask

  // Pick a register setting, extremes included, and stream random samples
  task automatic random_phase(input int unsigned n);
    logic [CfgDataW-1:0] step_v;
    case ($urandom_range(0, 9))
      0:       step_v = 21'd16384;
      1:       step_v = 21'd1048576;
      2:       step_v = CfgDataW'($urandom);
      3:       step_v = CfgDataW'($urandom_range(1, 16383));
      default: step_v = CfgDataW'($urandom_range(16384, 131072));
    endcase
    write_reg(CfgRateStep, step_v);
    if ($urandom_range(0, 4) == 0) write_reg(CfgNumChannels, CfgDataW'($urandom_range(0, 15)));
    else                           write_reg(CfgNumChannels, CfgDataW'($urandom_range(1, 8)));
    write_reg(CfgStartPhase, CfgDataW'($urandom_range(0, 65535)));
    send_random(n);
    settle();
  endtask

  task automatic test_random_settings();
    repeat (5) random_phase(35);
  endtask

  // Hold the output off for a long stretch while the input keeps coming
  task automatic test_output_holdoff();
    write_reg(CfgNumChannels, 21'd8);
    write_reg(CfgRateStep, 21'd16384);
    rx_hold = LongHold;
    send_random(30);
    settle();
  endtask

  // Pause the input mid-stream until every result is out
  task automatic test_input_pause();
    write_reg(CfgNumChannels, 21'd3);
    write_reg(CfgRateStep, 21'd50000);
    send_random(14);
    drain_results();
    send_random(16);
    settle();
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_full_rate();
    idle_on = 1'b0;
    write_reg(CfgNumChannels, 21'd2);
    write_reg(CfgRateStep, 21'd45000);
    send_random(50);
    settle();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_priming_and_extremes();
    test_channel_limits();
    test_midframe_change();
    test_result_cap();
    test_phase_overflow();
    test_random_settings();
    test_output_holdoff();
    test_input_pause();
    test_full_rate();
    $display("Streamed %0d samples over many channel counts and rate steps;", n_items);
    $display("checked %0d results after %0d register writes.", n_results, n_writes);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(12 * 2000000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
